[rtl/core/ber_pkg.sv]
package ber_pkg;

  // Counter and fraction sizes.
  localparam int COUNT_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int RATIO_WIDTH   = FRACTION_BITS + 1;
  localparam int ERRCNT_WIDTH  = 32;
  localparam int STEP_WIDTH    = $clog2(FRACTION_BITS);

  // Symbol and register sizes.
  localparam int SYMBOL_WIDTH  = 8;
  localparam int BPS_WIDTH     = 4;
  localparam int POP_WIDTH     = $clog2(SYMBOL_WIDTH + 1);
  localparam int CFG_DATA_WIDTH = 4;

  localparam logic [BPS_WIDTH-1:0] BPS_RESET = BPS_WIDTH'(SYMBOL_WIDTH);
  localparam logic [BPS_WIDTH-1:0] BPS_MAX   = BPS_WIDTH'(SYMBOL_WIDTH);

  // Configuration register indexes.
  localparam logic REG_BITS_PER_SYMBOL = 1'b0;
  localparam logic REG_HOLD_COUNTING   = 1'b1;

  // Command codes.
  localparam logic CMD_COMPARE = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_DIVIDE,
    S_DONE
  } ber_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Number of differing bits among the low n bits of the two symbols.
  function automatic logic [POP_WIDTH-1:0] count_errors(
    input logic [SYMBOL_WIDTH-1:0] a,
    input logic [SYMBOL_WIDTH-1:0] b,
    input logic [BPS_WIDTH-1:0]    n
  );
    logic [SYMBOL_WIDTH-1:0] diff;
    logic [POP_WIDTH-1:0]    s;
    diff = a ^ b;
    s = '0;
    for (int i = 0; i < SYMBOL_WIDTH; i++) begin
      if (BPS_WIDTH'(i) < n) begin
        s = s + POP_WIDTH'(diff[i]);
      end
    end
    return s;
  endfunction

endpackage

[rtl/core/ber_divider.sv]
module ber_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ber_pkg::COUNT_WIDTH-1:0]    numerator,
  input  logic [ber_pkg::COUNT_WIDTH-1:0]    denominator,
  output ber_pkg::div_status_t               status,
  output logic [ber_pkg::RATIO_WIDTH-1:0]    quotient
);
  import ber_pkg::*;

  localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(FRACTION_BITS - 1);

  logic                     busy;
  logic                     done;
  logic [STEP_WIDTH-1:0]    step;
  logic [COUNT_WIDTH-1:0]   rem;
  logic [COUNT_WIDTH-1:0]   den;
  logic [RATIO_WIDTH-1:0]   quo;

  logic                     init_ge;
  logic [COUNT_WIDTH-1:0]   init_rem;
  logic [COUNT_WIDTH:0]     rem_shift;
  logic                     step_ge;
  logic [COUNT_WIDTH-1:0]   rem_next;

  // The remainder stays below the divisor, so one extra bit holds the shift.
  always_comb begin
    init_ge   = numerator >= denominator;
    init_rem  = init_ge ? numerator - denominator : numerator;
    rem_shift = {rem, 1'b0};
    step_ge   = rem_shift >= {1'b0, den};
    rem_next  = step_ge ? COUNT_WIDTH'(rem_shift - {1'b0, den}) : COUNT_WIDTH'(rem_shift);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= denominator;
      rem <= init_rem;
      quo <= RATIO_WIDTH'(init_ge);
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[RATIO_WIDTH-2:0], step_ge};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule

[rtl/core/bit_error_rate_counter.sv]
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   cmd, reference_symbol, received_symbol
// output    out        out_valid / out_ready error_ratio, error_count, counters_saturated
// config    in         cfg_write             cfg_index, cfg_data
//
// An item goes from acceptance to a loaded result in steps: S_START loads the divider,
// the single restoring divider gives FRACTION_BITS fraction bits at one quotient bit a
// cycle, S_DIVIDE waits for its done flag and S_DONE loads the output. A new item is
// accepted only in S_IDLE. With no bits counted, S_START skips the divider for S_DONE.
// A result that is not taken holds the next item in its final state.
// Reset is synchronous and clears the counters.
module bit_error_rate_counter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic [ber_pkg::SYMBOL_WIDTH-1:0]     reference_symbol,
  input  logic [ber_pkg::SYMBOL_WIDTH-1:0]     received_symbol,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ber_pkg::RATIO_WIDTH-1:0]      error_ratio,
  output logic [ber_pkg::ERRCNT_WIDTH-1:0]     error_count,
  output logic                                 counters_saturated,
  input  logic                                 cfg_write,
  input  logic                                 cfg_index,
  input  logic [ber_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
  import ber_pkg::*;

  ber_state_t               state;
  ber_state_t               state_next;

  logic [BPS_WIDTH-1:0]     bits_per_symbol;
  logic                     hold_counting;
  logic [COUNT_WIDTH-1:0]   error_total;
  logic [COUNT_WIDTH-1:0]   bit_total;
  logic                     saturated_flag;

  logic                     accept;
  logic                     div_start;
  logic                     load_out;
  logic                     count_zero;
  logic [BPS_WIDTH-1:0]     n_bits;
  logic [COUNT_WIDTH:0]     bit_sum;
  logic [POP_WIDTH-1:0]     new_errors;

  div_status_t              div_status;
  logic [RATIO_WIDTH-1:0]   quotient;

  ber_divider u_divider (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .numerator   (error_total),
    .denominator (bit_total),
    .status      (div_status),
    .quotient    (quotient)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_symbol <= BPS_RESET;
      hold_counting   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BITS_PER_SYMBOL: bits_per_symbol <= cfg_data[BPS_WIDTH-1:0];
        REG_HOLD_COUNTING:   hold_counting   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The carry of the sum marks a bit counter that would overflow.
  always_comb begin
    n_bits     = (bits_per_symbol > BPS_MAX) ? BPS_MAX : bits_per_symbol;
    bit_sum    = {1'b0, bit_total} + (COUNT_WIDTH + 1)'(n_bits);
    new_errors = count_errors(reference_symbol, received_symbol, n_bits);
    count_zero = (bit_total == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_total    <= '0;
      bit_total      <= '0;
      saturated_flag <= 1'b0;
    end else if (accept) begin
      if (cmd == CMD_CLEAR) begin
        error_total    <= '0;
        bit_total      <= '0;
        saturated_flag <= 1'b0;
      end else if (!hold_counting && !saturated_flag && n_bits != '0) begin
        if (bit_sum[COUNT_WIDTH]) begin
          saturated_flag <= 1'b1;
        end else begin
          bit_total   <= bit_sum[COUNT_WIDTH-1:0];
          error_total <= error_total + COUNT_WIDTH'(new_errors);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_START;
      S_START:  state_next = count_zero ? S_DONE : S_DIVIDE;
      S_DIVIDE: if (div_status.done) state_next = S_DONE;
      S_DONE:   if (load_out) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      S_IDLE:   in_ready  = 1'b1;
      S_START:  div_start = !count_zero;
      S_DIVIDE: ;
      S_DONE:   load_out  = !out_valid || out_ready;
      default:  ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      error_ratio        <= count_zero ? '0 : quotient;
      error_count        <= count_zero ? '0 : ERRCNT_WIDTH'(error_total);
      counters_saturated <= saturated_flag;
    end
  end

endmodule
